### hw/rtl/lwac_pkg.sv
// lwac_pkg: shared widths, stage hand-off types and register indexes for the
// load weigh average classifier. No dependencies.
`timescale 1ns / 1ps

package lwac_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 19;
  localparam int FLAG_W   = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO     = 2'd3;

  // flag bit positions
  localparam int FLAG_OVERLOAD = 0;
  localparam int FLAG_FULL     = 1;
  localparam int FLAG_HALF     = 2;
  localparam int FLAG_ZERO     = 3;

  // window stage to divide stage
  typedef struct packed {
    logic             upd;
    logic [SUM_W-1:0] sum;
  } lwac_sum_t;

  // divide stage to classify stage
  typedef struct packed {
    logic                upd;
    logic [SAMPLE_W-1:0] avg;
  } lwac_avg_t;

endpackage

### hw/rtl/load_weigh_average_classifier.sv
// load_weigh_average_classifier: top level, window, divide and classify stages.
// Depends on lwac_pkg, lwac_window, lwac_divide, lwac_classify.
`timescale 1ns / 1ps

// Takes one load-cell sample per cycle, back to back while no result is
// held up, and returns one result per request, in order, through the
// window, divide and result registers. The ring of WINDOW samples is
// written at the write pointer while the entry at the next pointer is read
// ahead, so the oldest sample is always waiting in a register.
// The average comes from a 20 by 19 bit reciprocal multiply in its own
// stage, and the flag compare and history filter sit in front of the result
// register. Each stage holds one request and passes its ready back
// combinationally, so up to three requests are in flight and a waiting
// result stops the input once the stages behind it are full. The ring needs
// no clearing after reset; its entries are only used once it has been filled.
module load_weigh_average_classifier #(
  parameter int WINDOW = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [11:0] sample, [15:12] zero
  input  logic        in_tuser,    // [0] sample_ok
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [11:0] average, [15:12] raw_flags, [19:16] load_flags
  output logic        out_tuser,   // [0] average_valid
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  logic                s1_valid, s1_ready, s2_valid, s2_ready;
  lwac_pkg::lwac_sum_t s1_data;
  lwac_pkg::lwac_avg_t s2_data;
  logic [11:0]         avg;
  logic [3:0]          raw, load;

  lwac_window #(.WINDOW(WINDOW)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[11:0]),
    .in_ok     (in_tuser),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  lwac_divide #(.WINDOW(WINDOW)) u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  lwac_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s2_valid),
    .in_ready   (s2_ready),
    .in_data    (s2_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_avg    (avg),
    .out_avg_ok (out_tuser),
    .out_raw    (raw),
    .out_load   (load)
  );

  assign out_tdata = {4'b0, load, raw, avg};

endmodule

### hw/rtl/lwac_window.sv
// lwac_window: sample ring memory, write pointer, fill tracking and running sum.
// Depends on lwac_pkg.
`timescale 1ns / 1ps

module lwac_window #(
  parameter int WINDOW = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lwac_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lwac_pkg::lwac_sum_t           out_data
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  logic [lwac_pkg::SAMPLE_W-1:0] ring [WINDOW];
  logic [lwac_pkg::SAMPLE_W-1:0] oldest_r;
  logic [IDX_W-1:0]              wi_r, wi_nxt;
  logic                          filled_r, filled_nxt;
  logic [lwac_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                          valid_r;
  lwac_pkg::lwac_sum_t           data_r;
  logic                          accept, wr_en;
  logic [lwac_pkg::SUM_W-1:0]    sample_ext, oldest_ext;

  assign in_ready = !valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && in_ok;

  assign sample_ext = {{(lwac_pkg::SUM_W - lwac_pkg::SAMPLE_W){1'b0}}, in_sample};
  assign oldest_ext = {{(lwac_pkg::SUM_W - lwac_pkg::SAMPLE_W){1'b0}}, oldest_r};

  always_comb begin
    wi_nxt     = wi_r;
    filled_nxt = filled_r;
    sum_nxt    = sum_r;
    if (wr_en) begin
      wi_nxt = (wi_r == LAST_IDX) ? '0 : wi_r + 1'b1;
      if (filled_r) begin
        sum_nxt = sum_r - oldest_ext + sample_ext;
      end else begin
        sum_nxt = sum_r + sample_ext;
        if (wi_r == LAST_IDX) begin
          filled_nxt = 1'b1;
        end
      end
    end
  end

  // read the entry at the next write pointer so the oldest sample is ready
  // for the following request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wi_r] <= in_sample;
    end
    oldest_r <= ring[wi_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r     <= '0;
      filled_r <= 1'b0;
      sum_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      wi_r     <= wi_nxt;
      filled_r <= filled_nxt;
      sum_r    <= sum_nxt;
      if (in_ready) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r.upd <= in_ok && filled_r;
      data_r.sum <= sum_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hw/rtl/lwac_divide.sv
// lwac_divide: window average by multiplication with a reciprocal of WINDOW.
// Depends on lwac_pkg.
`timescale 1ns / 1ps

module lwac_divide #(
  parameter int WINDOW = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwac_pkg::lwac_sum_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lwac_pkg::lwac_avg_t out_data
);

  localparam int L_W     = $clog2(WINDOW);
  localparam int SHIFT   = lwac_pkg::SUM_W + L_W;
  localparam int RECIP_W = lwac_pkg::SUM_W + 1;
  localparam int PROD_W  = RECIP_W + lwac_pkg::SUM_W;
  // ceil(2^SHIFT / WINDOW) is exact for every sum of SUM_W bits
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic                valid_r;
  lwac_pkg::lwac_avg_t data_r;
  logic [PROD_W-1:0]   prod;

  assign in_ready = !valid_r || out_ready;
  assign prod     = PROD_W'(in_data.sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r.upd <= in_data.upd;
      data_r.avg <= prod[SHIFT +: lwac_pkg::SAMPLE_W];
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hw/rtl/lwac_classify.sv
// lwac_classify: limit registers, threshold compare, flag history filter and
// the result register. Depends on lwac_pkg.
`timescale 1ns / 1ps

module lwac_classify (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lwac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lwac_pkg::SAMPLE_W-1:0]  cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lwac_pkg::lwac_avg_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lwac_pkg::SAMPLE_W-1:0]  out_avg,
  output logic                           out_avg_ok,
  output logic [lwac_pkg::FLAG_W-1:0]    out_raw,
  output logic [lwac_pkg::FLAG_W-1:0]    out_load
);

  logic [lwac_pkg::SAMPLE_W-1:0] lim_r [lwac_pkg::FLAG_W];
  logic [lwac_pkg::SAMPLE_W-1:0] avg_r;
  logic                          avg_ok_r;
  logic [lwac_pkg::FLAG_W-1:0]   hist0_r, hist1_r, filt_r;
  logic [lwac_pkg::FLAG_W-1:0]   hist0_nxt, filt_nxt, x;
  logic                          valid_r, take, normal, inverted;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  assign normal   = lim_r[lwac_pkg::FLAG_OVERLOAD] > lim_r[lwac_pkg::FLAG_ZERO];
  assign inverted = lim_r[lwac_pkg::FLAG_OVERLOAD] < lim_r[lwac_pkg::FLAG_ZERO];

  always_comb begin
    hist0_nxt = hist0_r;
    for (int i = 0; i < lwac_pkg::FLAG_W; i++) begin
      if (lim_r[i] != '0) begin
        // the empty-car flag compares the other way round
        if (normal) begin
          hist0_nxt[i] = (i == lwac_pkg::FLAG_ZERO) ? (in_data.avg < lim_r[i])
                                                    : (in_data.avg > lim_r[i]);
        end else if (inverted) begin
          hist0_nxt[i] = (i == lwac_pkg::FLAG_ZERO) ? (in_data.avg > lim_r[i])
                                                    : (in_data.avg < lim_r[i]);
        end
      end
    end
    // after the shift the two older entries are the current hist0 and hist1
    x        = hist0_nxt ^ hist0_r ^ hist1_r;
    filt_nxt = (filt_r & x) | (hist0_nxt & ~x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lwac_pkg::FLAG_W; i++) begin
        lim_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        lwac_pkg::REG_OVERLOAD: lim_r[lwac_pkg::FLAG_OVERLOAD] <= cfg_wdata;
        lwac_pkg::REG_FULL:     lim_r[lwac_pkg::FLAG_FULL]     <= cfg_wdata;
        lwac_pkg::REG_HALF:     lim_r[lwac_pkg::FLAG_HALF]     <= cfg_wdata;
        lwac_pkg::REG_ZERO:     lim_r[lwac_pkg::FLAG_ZERO]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      avg_r    <= '0;
      avg_ok_r <= 1'b0;
      hist0_r  <= '0;
      hist1_r  <= '0;
      filt_r   <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (take) begin
        // history shifts on every request, timed-out ones included
        hist1_r <= hist0_r;
        if (in_data.upd) begin
          hist0_r  <= hist0_nxt;
          filt_r   <= filt_nxt;
          avg_r    <= in_data.avg;
          avg_ok_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid  = valid_r;
  assign out_avg    = avg_r;
  assign out_avg_ok = avg_ok_r;
  assign out_raw    = hist0_r;
  assign out_load   = filt_r;

endmodule

### hw/rtl/lwac_checker.sv
// lwac_checker: port-level assertions for the classifier and the bind that
// attaches them to load_weigh_average_classifier. No package dependency.
`timescale 1ns / 1ps

module lwac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // a result waiting for the sink stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // once an average exists it stays valid until the next reset
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && $past(rst_n) |-> !$fell(out_tuser))
    else $error("average valid dropped");

  // before the window fills, average and both flag sets read zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 24'd0)
    else $error("nonzero result before first average");

endmodule

bind load_weigh_average_classifier lwac_checker u_lwac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### bench/tb_load_weigh_average_classifier.sv
// tb_load_weigh_average_classifier: self-checking bench for the load weigh average
// classifier; predicts average, raw and filtered flags for every request and checks them.
// Depends on lwac_pkg and load_weigh_average_classifier.
`timescale 1ns / 1ps

module tb_load_weigh_average_classifier;

  localparam int WINDOW      = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SAMPLE_W    = lwac_pkg::SAMPLE_W;

  typedef struct packed {
    logic [SAMPLE_W-1:0]         average;
    logic                        avg_valid;
    logic [lwac_pkg::FLAG_W-1:0] raw;
    logic [lwac_pkg::FLAG_W-1:0] load;
  } weigh_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  load_weigh_average_classifier #(.WINDOW(WINDOW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [SAMPLE_W-1:0]          lim_overload, lim_full, lim_half, lim_zero;
  logic [SAMPLE_W-1:0]          ring [WINDOW];
  int                           wr_ptr, fill_cnt;
  logic [lwac_pkg::SUM_W-1:0]   win_sum;
  logic [SAMPLE_W-1:0]          avg_now;
  logic                         avg_ok;
  logic [lwac_pkg::FLAG_W-1:0]  hist [3];
  logic [lwac_pkg::FLAG_W-1:0]  filt_flags;

  weigh_result_t pending_weighs[$];
  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic [lwac_pkg::FLAG_W-1:0] classify_average(
      logic [lwac_pkg::FLAG_W-1:0] flags, logic [SAMPLE_W-1:0] a);
    if (lim_overload > lim_zero) begin
      if (lim_overload != 0) flags[lwac_pkg::FLAG_OVERLOAD] = a > lim_overload;
      if (lim_full != 0)     flags[lwac_pkg::FLAG_FULL]     = a > lim_full;
      if (lim_half != 0)     flags[lwac_pkg::FLAG_HALF]     = a > lim_half;
      if (lim_zero != 0)     flags[lwac_pkg::FLAG_ZERO]     = a < lim_zero;
    end else if (lim_overload < lim_zero) begin
      if (lim_overload != 0) flags[lwac_pkg::FLAG_OVERLOAD] = a < lim_overload;
      if (lim_full != 0)     flags[lwac_pkg::FLAG_FULL]     = a < lim_full;
      if (lim_half != 0)     flags[lwac_pkg::FLAG_HALF]     = a < lim_half;
      if (lim_zero != 0)     flags[lwac_pkg::FLAG_ZERO]     = a > lim_zero;
    end
    return flags;
  endfunction

  task automatic predict_weigh(input logic [SAMPLE_W-1:0] s, input logic ok);
    logic [lwac_pkg::FLAG_W-1:0] x;
    weigh_result_t r;
    hist[2] = hist[1];
    hist[1] = hist[0];
    if (ok) begin
      if (fill_cnt < WINDOW) begin
        ring[wr_ptr] = s;
        win_sum = win_sum + s;
        fill_cnt++;
      end else begin
        win_sum = win_sum - ring[wr_ptr] + s;
        ring[wr_ptr] = s;
        avg_now = SAMPLE_W'(win_sum / WINDOW);
        avg_ok = 1'b1;
        hist[0] = classify_average(hist[0], avg_now);
        x = hist[0] ^ hist[1] ^ hist[2];
        filt_flags = (filt_flags & x) | (hist[0] & ~x);
      end
      wr_ptr = (wr_ptr == WINDOW - 1) ? 0 : wr_ptr + 1;
    end
    r.average   = avg_now;
    r.avg_valid = avg_ok;
    r.raw       = hist[0];
    r.load      = filt_flags;
    pending_weighs.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    weigh_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_weighs.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[11:0], 0);
      end else begin
        want = pending_weighs.pop_front();
        if (out_tdata[11:0] != want.average) report_mismatch("average", out_tdata[11:0],
                                                             want.average);
        if (out_tuser != want.avg_valid) report_mismatch("average_valid", out_tuser,
                                                         want.avg_valid);
        if (out_tdata[15:12] != want.raw) report_mismatch("raw_flags", out_tdata[15:12],
                                                          want.raw);
        if (out_tdata[19:16] != want.load) report_mismatch("load_flags", out_tdata[19:16],
                                                           want.load);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_load_weigh_average_classifier: errors");
      $finish;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic ok);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, s};
    in_tuser  <= ok;
    do @(posedge clk); while (!in_tready);
    predict_weigh(s, ok);
    @(negedge clk);
  endtask

  // good sample in [lo, hi], with a timed-out one now and then
  task automatic send_range(input int n, input int lo, input int hi);
    for (int i = 0; i < n; i++) begin
      send_sample(SAMPLE_W'($urandom_range(hi, lo)), $urandom_range(99) >= 10);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_weighs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lwac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lwac_pkg::REG_OVERLOAD: lim_overload = val;
      lwac_pkg::REG_FULL:     lim_full = val;
      lwac_pkg::REG_HALF:     lim_half = val;
      lwac_pkg::REG_ZERO:     lim_zero = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_limit(int v);
    if (v < 1) return SAMPLE_W'(1);
    if (v > 4095) return SAMPLE_W'(4095);
    return SAMPLE_W'(v);
  endfunction

  task automatic test_directed_fill();
    send_idle_pct = 11;
    recv_idle_pct = 75;
    send_sample(12'h000, 1'b1);
    send_sample(12'hfff, 1'b1);
    send_sample(12'hfff, 1'b0);
    send_sample(12'h000, 1'b0);
    send_sample(12'haaa, 1'b1);
    send_sample(12'h555, 1'b0);
    send_sample(12'h555, 1'b1);
    send_sample(12'haaa, 1'b0);
    send_range(12, 0, 4095);
  endtask

  task automatic test_window_fill();
    // keep going until the window is full, then a few averaged requests
    while (fill_cnt < WINDOW) send_range(1, 0, 4095);
    send_range(6, 0, 4095);
  endtask

  task automatic test_normal_polarity();
    int base;
    wait_drained();
    base = avg_now;
    write_reg(lwac_pkg::REG_OVERLOAD, clamp_limit(base + 30));
    write_reg(lwac_pkg::REG_FULL, clamp_limit(base + 15));
    write_reg(lwac_pkg::REG_HALF, clamp_limit(base));
    write_reg(lwac_pkg::REG_ZERO, clamp_limit(base - 15));
    send_range(15, 3000, 4095);
    send_range(15, 0, 1000);
  endtask

  task automatic test_inverted_polarity();
    int base;
    send_idle_pct = 75;
    recv_idle_pct = 11;
    wait_drained();
    base = avg_now;
    write_reg(lwac_pkg::REG_OVERLOAD, clamp_limit(base - 30));
    write_reg(lwac_pkg::REG_FULL, clamp_limit(base - 15));
    write_reg(lwac_pkg::REG_HALF, clamp_limit(base));
    write_reg(lwac_pkg::REG_ZERO, clamp_limit(base + 15));
    send_range(15, 0, 1000);
    send_range(15, 3000, 4095);
  endtask

  task automatic test_equal_and_disabled();
    int base;
    wait_drained();
    base = avg_now;
    // equal overload and zero limits hold the flags
    write_reg(lwac_pkg::REG_OVERLOAD, clamp_limit(base));
    write_reg(lwac_pkg::REG_ZERO, clamp_limit(base));
    send_range(10, 0, 4095);
    wait_drained();
    write_reg(lwac_pkg::REG_OVERLOAD, 12'd0);
    write_reg(lwac_pkg::REG_FULL, 12'd0);
    write_reg(lwac_pkg::REG_HALF, 12'd0);
    write_reg(lwac_pkg::REG_ZERO, 12'd0);
    send_range(10, 0, 4095);
    wait_drained();
    base = avg_now;
    write_reg(lwac_pkg::REG_OVERLOAD, clamp_limit(base + 20));
    write_reg(lwac_pkg::REG_HALF, clamp_limit(base));
    send_range(8, 3000, 4095);
    send_range(8, 0, 1000);
  endtask

  task automatic test_average_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    write_reg(lwac_pkg::REG_OVERLOAD, 12'd4094);
    write_reg(lwac_pkg::REG_FULL, 12'd4095);
    write_reg(lwac_pkg::REG_HALF, 12'd1);
    write_reg(lwac_pkg::REG_ZERO, 12'd1);
    // WINDOW + 5 requests at full scale, then WINDOW + 5 at zero, some timed out
    for (int i = 0; i < WINDOW + 5; i++) send_sample(12'hfff, i % 17 != 3);
    for (int i = 0; i < WINDOW + 5; i++) send_sample(12'h000, i % 13 != 5);
  endtask

  initial begin
    lim_overload = '0;
    lim_full = '0;
    lim_half = '0;
    lim_zero = '0;
    wr_ptr = 0;
    fill_cnt = 0;
    win_sum = '0;
    avg_now = '0;
    avg_ok = 1'b0;
    hist[0] = '0;
    hist[1] = '0;
    hist[2] = '0;
    filt_flags = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_fill();
    test_window_fill();
    test_normal_polarity();
    test_inverted_polarity();
    test_equal_and_disabled();
    test_average_extremes();
    wait_drained();
    if (err_count == 0) begin
      $display("tb_load_weigh_average_classifier: clean");
    end else begin
      $display("tb_load_weigh_average_classifier: errors");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lwac_pkg.sv
hw/rtl/lwac_window.sv
hw/rtl/lwac_divide.sv
hw/rtl/lwac_classify.sv
hw/rtl/load_weigh_average_classifier.sv
hw/rtl/lwac_checker.sv
bench/tb_load_weigh_average_classifier.sv
